// ----- sv/acme_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acme_pkg
// Shared types and constants of the accumulator machine executor: opcode
// encoding, field widths and the decoded instruction item.
// ----------------------------------------------------------------------------
package acme_pkg;

  localparam int ADDR_W = 10;
  localparam int DATA_W = 32;
  localparam int OP_W   = 4;

  typedef enum logic [OP_W-1:0] {
    OP_NOP       = 4'd0,
    OP_SET       = 4'd1,
    OP_LOAD      = 4'd2,
    OP_ADD_ACC   = 4'd3,
    OP_ADD_TWO   = 4'd4,
    OP_ADD_THREE = 4'd5,
    OP_INC       = 4'd6,
    OP_DEC       = 4'd7,
    OP_STORE     = 4'd8,
    OP_SHOW_ACC  = 4'd9,
    OP_SHOW_CNT  = 4'd10,
    OP_SHOW_AR   = 4'd11,
    OP_SHOW_DR   = 4'd12,
    OP_SHOW_MEM  = 4'd13,
    OP_END       = 4'd14
  } op_t;

  typedef struct packed {
    op_t                opcode;
    logic [ADDR_W-1:0]  addr_a;
    logic [ADDR_W-1:0]  addr_b;
    logic [ADDR_W-1:0]  addr_c;
    logic [DATA_W-1:0]  set_value;
  } item_t;

endpackage

// ----- sv/acme_dmem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acme_dmem
// Data memory: one write port, one read port with registered read data and
// write-to-read forwarding, plus a clearing pass that zeroes every word
// after reset.
// ----------------------------------------------------------------------------
module acme_dmem #(
  parameter int MEM_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  output logic                          busy,
  input  logic [$clog2(MEM_DEPTH)-1:0]  raddr,
  output logic [acme_pkg::DATA_W-1:0]   rdata,
  input  logic                          we,
  input  logic [$clog2(MEM_DEPTH)-1:0]  waddr,
  input  logic [acme_pkg::DATA_W-1:0]   wdata
);
  import acme_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(MEM_DEPTH - 1);

  logic [DATA_W-1:0] mem_r [MEM_DEPTH];
  logic [DATA_W-1:0] rdat_r;
  logic [DATA_W-1:0] fwd_data_r;
  logic              fwd_r;
  logic              clr_busy_r, clr_busy_nxt;
  logic [AW-1:0]     clr_idx_r, clr_idx_nxt;

  logic              we_eff;
  logic [AW-1:0]     waddr_eff;
  logic [DATA_W-1:0] wdata_eff;

  // Advance the clearing pass one word per cycle
  always_comb begin
    clr_idx_nxt  = clr_idx_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_idx_nxt  = clr_idx_r + 1'b1;
      clr_busy_nxt = (clr_idx_r != LAST_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  // Clearing owns the write port while it runs
  assign we_eff    = clr_busy_r | we;
  assign waddr_eff = clr_busy_r ? clr_idx_r : waddr;
  assign wdata_eff = clr_busy_r ? '0 : wdata;

  // Write, read, and note a same-cycle write to the read address
  always_ff @(posedge clk) begin
    if (we_eff) begin
      mem_r[waddr_eff] <= wdata_eff;
    end
    rdat_r     <= mem_r[raddr];
    fwd_r      <= we_eff && (waddr_eff == raddr);
    fwd_data_r <= wdata_eff;
  end

  assign rdata = fwd_r ? fwd_data_r : rdat_r;
  assign busy  = clr_busy_r;

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_busy_r |=> !clr_busy_r)
    else $error("memory clearing pass restarted outside reset");

endmodule

// ----- sv/acme_exec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acme_exec
// Execute stage: holds one instruction item, reads its operands from the
// data memory, updates the accumulator or writes memory back, and drives
// the result register for show instructions.
// ----------------------------------------------------------------------------
module acme_exec #(
  parameter int MEM_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  acme_pkg::item_t               in_item,
  input  logic                          in_take,
  output logic                          busy,
  input  logic [acme_pkg::DATA_W-1:0]   icount,
  output logic [$clog2(MEM_DEPTH)-1:0]  mem_raddr,
  input  logic [acme_pkg::DATA_W-1:0]   mem_rdata,
  output logic                          mem_we,
  output logic [$clog2(MEM_DEPTH)-1:0]  mem_waddr,
  output logic [acme_pkg::DATA_W-1:0]   mem_wdata,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [acme_pkg::DATA_W-1:0] out_show_value
);
  import acme_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);
  localparam logic [16:0] DEPTH_V = 17'(MEM_DEPTH);

  item_t             x_r;
  logic              x_valid_r, x_valid_nxt;
  logic              x_phase_r, x_phase_nxt;
  logic [DATA_W-1:0] a_data_r;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r;

  logic              a_ok, b_ok, c_ok;
  logic [AW-1:0]     a_idx, b_idx, c_idx;
  logic              needs_b, step_b;
  logic              show_now, x_blocked, x_adv;
  logic [DATA_W-1:0] show_val;
  logic [DATA_W-1:0] sum;

  // Range checks and memory indexes
  assign a_ok  = ({7'b0, x_r.addr_a} < DEPTH_V);
  assign b_ok  = ({7'b0, x_r.addr_b} < DEPTH_V);
  assign c_ok  = ({7'b0, x_r.addr_c} < DEPTH_V);
  assign a_idx = AW'(x_r.addr_a);
  assign b_idx = AW'(x_r.addr_b);
  assign c_idx = AW'(x_r.addr_c);

  // Two- and three-operand adds need a second read when all their addresses are in range
  assign needs_b = ((x_r.opcode == OP_ADD_TWO) && a_ok && b_ok) ||
                   ((x_r.opcode == OP_ADD_THREE) && a_ok && b_ok && c_ok);
  assign step_b  = x_valid_r && !x_phase_r && needs_b;
  assign sum     = a_data_r + mem_rdata;

  // Execute the held item
  always_comb begin
    show_now  = 1'b0;
    show_val  = '0;
    mem_we    = 1'b0;
    mem_waddr = a_idx;
    mem_wdata = '0;
    acc_nxt   = acc_r;
    if (x_valid_r && x_phase_r) begin
      case (x_r.opcode)
        OP_ADD_TWO:   acc_nxt = sum;
        OP_ADD_THREE: begin
          mem_we    = 1'b1;
          mem_waddr = c_idx;
          mem_wdata = sum;
        end
        default: ;
      endcase
    end else if (x_valid_r) begin
      case (x_r.opcode)
        OP_SET: begin
          mem_we    = a_ok;
          mem_wdata = x_r.set_value;
        end
        OP_LOAD: begin
          if (a_ok) acc_nxt = mem_rdata;
        end
        OP_ADD_ACC: begin
          if (a_ok) acc_nxt = acc_r + mem_rdata;
        end
        OP_INC: begin
          mem_we    = a_ok;
          mem_wdata = mem_rdata + 32'd1;
        end
        OP_DEC: begin
          mem_we    = a_ok;
          mem_wdata = mem_rdata - 32'd1;
        end
        OP_STORE: begin
          mem_we    = a_ok;
          mem_wdata = acc_r;
        end
        OP_SHOW_ACC: begin
          show_now = 1'b1;
          show_val = acc_r;
        end
        OP_SHOW_CNT: begin
          show_now = 1'b1;
          show_val = icount;
        end
        OP_SHOW_AR, OP_SHOW_DR: show_now = 1'b1;
        OP_SHOW_MEM: begin
          show_now = a_ok;
          show_val = mem_rdata;
        end
        default: ;
      endcase
    end
  end

  // Hold a show while the result register is full and stalled
  assign x_blocked = show_now && out_valid_r && out_stall;
  assign x_adv     = x_valid_r && !step_b && !x_blocked;
  assign busy      = x_valid_r && !x_adv;

  // Read the second operand, re-read a held operand, or read the next item
  always_comb begin
    if (busy) begin
      mem_raddr = step_b ? b_idx : a_idx;
    end else begin
      mem_raddr = AW'(in_item.addr_a);
    end
  end

  // Advance the execute stage
  always_comb begin
    x_valid_nxt = x_valid_r;
    x_phase_nxt = x_phase_r;
    if (in_take) begin
      x_valid_nxt = 1'b1;
      x_phase_nxt = 1'b0;
    end else if (step_b) begin
      x_phase_nxt = 1'b1;
    end else if (x_adv) begin
      x_valid_nxt = 1'b0;
      x_phase_nxt = 1'b0;
    end
  end

  assign out_valid_nxt = (show_now && !x_blocked) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_valid_r   <= 1'b0;
      x_phase_r   <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      x_valid_r   <= x_valid_nxt;
      x_phase_r   <= x_phase_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      x_r <= in_item;
    end
    if (step_b) begin
      a_data_r <= mem_rdata;
    end
    if (show_now && !x_blocked) begin
      out_value_r <= show_val;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_show_value = out_value_r;

  a_phase_order: assert property (@(posedge clk) disable iff (!rst_n)
    (x_valid_r && x_phase_r) |-> $past(x_valid_r && !x_phase_r))
    else $error("second operand phase entered without a first phase");

  a_phase_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (x_valid_r && x_phase_r) |-> x_adv)
    else $error("second operand phase failed to complete");

  a_hold_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    x_blocked |-> !mem_we)
    else $error("memory written while a show item is held");

endmodule

// ----- sv/accumulator_machine_executor_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_machine_executor_unit
// Executes decoded instructions of a small accumulator machine against a
// word-addressed data memory of MEM_DEPTH 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one decoded instruction per item, accepted when
//   in_valid is high and in_stall is low. Result channel (out_*): one item
//   per executed show instruction, except a memory show whose address is
//   out of range, taken when out_valid is high and out_stall low.
//   Throughput: one item per cycle unless clearing or a held show stalls the
//   input; in-range two- and three-operand adds hold the next item for a
//   second read, as both operands share the single read port of the data
//   memory. Show results: the item and its operand read are registered on
//   acceptance, and the result register loads from them as the item executes.
//   Reset: the accumulator, instruction counter and halt flag clear at once;
//   the data memory is then zeroed by a clearing pass over all MEM_DEPTH
//   words, during which in_stall stays high.
//   After an end instruction, further items are accepted and dropped.
//   When the receiver stalls, the result register holds its item; the
//   block keeps taking items until a second show item needs the register.
// ----------------------------------------------------------------------------
module accumulator_machine_executor_unit #(
  parameter int MEM_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          in_opcode,
  input  logic [9:0]          in_addr_a,
  input  logic [9:0]          in_addr_b,
  input  logic [9:0]          in_addr_c,
  input  logic signed [31:0]  in_set_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_show_value
);
  import acme_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);

  logic              halted_r, halted_nxt;
  logic [DATA_W-1:0] cnt_r, cnt_nxt;
  logic              mem_busy, x_busy;
  logic              in_take, run_take;
  item_t             in_item;

  logic [AW-1:0]     mem_raddr, mem_waddr;
  logic [DATA_W-1:0] mem_rdata, mem_wdata;
  logic              mem_we;

  // Pack the input fields
  assign in_item.opcode    = op_t'(in_opcode);
  assign in_item.addr_a    = in_addr_a;
  assign in_item.addr_b    = in_addr_b;
  assign in_item.addr_c    = in_addr_c;
  assign in_item.set_value = in_set_value;

  // Accept items unless clearing or the execute stage holds
  assign in_stall = mem_busy || x_busy;
  assign in_take  = in_valid && !in_stall;
  assign run_take = in_take && !halted_r;

  // Count running items and latch the halt
  assign cnt_nxt    = run_take ? cnt_r + 32'd1 : cnt_r;
  assign halted_nxt = halted_r || (run_take && (in_item.opcode == OP_END));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      halted_r <= halted_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  acme_exec #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_exec (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_item        (in_item),
    .in_take        (run_take),
    .busy           (x_busy),
    .icount         (cnt_r),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_show_value (out_show_value)
  );

  acme_dmem #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .busy  (mem_busy),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    run_take |=> (cnt_r == $past(cnt_r) + 32'd1))
    else $error("instruction counter missed a running item");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> (halted_r && $stable(cnt_r)))
    else $error("halted block resumed or counted");

endmodule
